// ===== sv/bfs_pkg.sv =====
// Package: sizes, op codes, summary structs and helper functions for the bitmap block.
`default_nettype none
package bfs_pkg;

  localparam int BITS      = 1024;
  localparam int WORD_BITS = 64;
  localparam int NWORDS    = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int IDX_W     = 10;
  localparam int OP_W      = 3;

  localparam logic [OP_W-1:0] OP_TEST  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_FLIP  = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [BIT_AW-1:0]    baddr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH
  } state_t;

  // Update of one word's summary, or a whole-map fill.
  typedef struct packed {
    logic   wr;
    logic   fill;
    logic   fill_val;
    waddr_t word;
    logic   nz;
    logic   full;
  } sum_upd_t;

  // Summary answers for the controller.
  typedef struct packed {
    logic   hit;
    waddr_t fword;
    logic   stale;
    logic   fill_val;
    logic   all_clear;
    logic   all_set;
  } sum_qry_t;

  // Positions of word k that lie below BITS.
  function automatic word_t valid_mask(input waddr_t k);
    int rem;
    rem = BITS - int'(k) * WORD_BITS;
    if (rem >= WORD_BITS) return '1;
    return (word_t'(1) << rem) - word_t'(1);
  endfunction

  function automatic baddr_t first_one_word(input word_t c);
    baddr_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (c[i]) r = baddr_t'(i);
    end
    return r;
  endfunction

  function automatic waddr_t first_one_map(input logic [NWORDS-1:0] c);
    waddr_t r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (c[i]) r = waddr_t'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bfs_word_ram.sv =====
// Word store of the bitmap: one write port, one registered read port.
`default_nettype none
module bfs_word_ram (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire bfs_pkg::waddr_t rd_addr,
  output bfs_pkg::word_t       rd_data,
  input  wire logic            wr_en,
  input  wire bfs_pkg::waddr_t wr_addr,
  input  wire bfs_pkg::word_t  wr_data
);
  import bfs_pkg::*;

  word_t mem [NWORDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== sv/bfs_summary.sv =====
// Per-word summary flags, fill-pending marks and the word-level search.
`default_nettype none
module bfs_summary (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfs_pkg::sum_upd_t upd,
  input  wire logic              q_val,
  input  wire bfs_pkg::waddr_t   q_word,
  output bfs_pkg::sum_qry_t      qry
);
  import bfs_pkg::*;

  logic [NWORDS-1:0] nz_r, nz_nxt;
  logic [NWORDS-1:0] full_r, full_nxt;
  logic [NWORDS-1:0] stale_r, stale_nxt;
  logic              fill_val_r, fill_val_nxt;
  logic [NWORDS-1:0] cand;

  always_comb begin
    nz_nxt       = nz_r;
    full_nxt     = full_r;
    stale_nxt    = stale_r;
    fill_val_nxt = fill_val_r;
    if (upd.fill) begin
      // mark every word as holding the fill pattern
      stale_nxt    = '1;
      fill_val_nxt = upd.fill_val;
      nz_nxt       = {NWORDS{upd.fill_val}};
      full_nxt     = {NWORDS{upd.fill_val}};
    end else if (upd.wr) begin
      stale_nxt[upd.word] = 1'b0;
      nz_nxt[upd.word]    = upd.nz;
      full_nxt[upd.word]  = upd.full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r       <= '0;
      full_r     <= '0;
      stale_r    <= '1;
      fill_val_r <= 1'b0;
    end else begin
      nz_r       <= nz_nxt;
      full_r     <= full_nxt;
      stale_r    <= stale_nxt;
      fill_val_r <= fill_val_nxt;
    end
  end

  assign cand = q_val ? nz_r : ~full_r;

  always_comb begin
    qry.hit       = |cand;
    qry.fword     = first_one_map(cand);
    qry.stale     = stale_r[q_word];
    qry.fill_val  = fill_val_r;
    qry.all_clear = ~|nz_nxt;
    qry.all_set   = &full_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/bitmap_find_first_set_clear_top.sv =====
// Top level: allocation bitmap with bit test/write/flip, fill and find-first.
//
// Usage: present in_op, in_index and in_value with start high; the request
// transfers at the rising edge where start is high and busy is low. busy
// rises right after the transfer and stays high while the request runs.
// Each request yields one result, shown on the out_ ports for exactly one
// cycle with out_valid high; the receiver cannot stall, so take it then.
// Test, write, flip and fill pass through the exec state, a find through
// exec and then search; out_valid is registered from the last of these. A
// new request transfers only once busy is low again. The store's read is
// registered: the word is read at the transfer, then modified, written back
// and the result registered in exec. A find reads the word at in_index (for
// out_bit_value), then the first candidate picked by the per-word summary flags.
// Fill only rewrites the summary and marks every word as holding the fill
// pattern, so it takes no sweep through the store.
// Reset: synchronous, active low; the map reads as all zeros right after
// reset, with no clearing pass, and the block is idle.
`default_nettype none
module bitmap_find_first_set_clear_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_op,
  input  wire logic [9:0]            in_index,
  input  wire logic                  in_value,
  output logic                       out_valid,
  output logic                       out_bit_value,
  output logic                       out_found,
  output logic [9:0]                 out_found_index,
  output logic                       out_all_clear,
  output logic                       out_all_set
);
  import bfs_pkg::*;

  state_t          state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  waddr_t          word_r;
  baddr_t          bit_r;
  logic            inrng_r;
  logic            val_r;
  logic            hit_r;
  waddr_t          fword_r;
  logic            stale_r;
  logic            fillv_r;
  logic            before_r;

  logic            rd_en;
  waddr_t          rd_addr;
  word_t           rd_data;
  logic            done;
  sum_upd_t        upd;
  sum_qry_t        qry;

  waddr_t          cur_word;
  word_t           cur_mask;
  word_t           w;
  logic            before_bit;
  logic            new_bit;
  word_t           nw;
  word_t           cand;

  logic            out_valid_r;
  logic            out_bit_r;
  logic            out_found_r;
  logic [IDX_W-1:0] out_fidx_r;
  logic            out_ac_r;
  logic            out_as_r;

  // ---------------------------------------------------------------------
  // Control: idle -> exec (read, modify, write back) -> optional search
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = in_index[IDX_W-1:BIT_AW];
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_FIND) begin
          // second read: first word that holds the searched value
          rd_en     = 1'b1;
          rd_addr   = fword_r;
          state_nxt = ST_SRCH;
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SRCH: begin
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Capture the request at the transfer.
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      op_r    <= in_op;
      word_r  <= in_index[IDX_W-1:BIT_AW];
      bit_r   <= in_index[BIT_AW-1:0];
      inrng_r <= (int'(in_index) < BITS);
      val_r   <= in_value;
      hit_r   <= qry.hit;
      fword_r <= qry.fword;
    end
  end

  // Fill-pending mark of the word being read travels with its data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      stale_r <= qry.stale;
      fillv_r <= qry.fill_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      before_r <= before_bit;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath: effective word, bit modify, in-word priority encode
  // ---------------------------------------------------------------------
  assign cur_word   = (state_r == ST_SRCH) ? fword_r : word_r;
  assign cur_mask   = valid_mask(cur_word);
  assign w          = stale_r ? (fillv_r ? cur_mask : '0) : rd_data;
  assign before_bit = inrng_r & w[bit_r];
  assign new_bit    = (op_r == OP_WRITE) ? val_r : ~before_bit;
  assign nw         = (w & ~(word_t'(1) << bit_r)) | (word_t'(new_bit) << bit_r);
  assign cand       = (val_r ? w : ~w) & cur_mask;

  always_comb begin
    upd          = '0;
    upd.word     = word_r;
    upd.fill_val = val_r;
    upd.nz       = |(nw & cur_mask);
    upd.full     = ((nw & cur_mask) == cur_mask);
    if (state_r == ST_EXEC) begin
      upd.wr   = inrng_r && ((op_r == OP_WRITE) || (op_r == OP_FLIP));
      upd.fill = (op_r == OP_FILL);
    end
  end

  bfs_word_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (upd.wr),
    .wr_addr (word_r),
    .wr_data (nw)
  );

  bfs_summary u_summary (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (upd),
    .q_val  (in_value),
    .q_word (rd_addr),
    .qry    (qry)
  );

  // ---------------------------------------------------------------------
  // Result register: one-cycle strobe, no back-pressure
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_ac_r <= qry.all_clear;
      out_as_r <= qry.all_set;
      if (state_r == ST_SRCH) begin
        out_bit_r   <= before_r;
        out_found_r <= hit_r;
        out_fidx_r  <= hit_r ? IDX_W'({fword_r, first_one_word(cand)}) : '0;
      end else begin
        out_bit_r   <= before_bit;
        out_found_r <= 1'b0;
        out_fidx_r  <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = out_bit_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_fidx_r;
  assign out_all_clear   = out_ac_r;
  assign out_all_set     = out_as_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a transfer");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r != OP_FIND) |=> out_valid)
    else $error("no result after a non-find request");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still running");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_index == '0))
    else $error("found_index nonzero without a hit");

  a_clear_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_all_clear && out_all_set))
    else $error("map reported both all clear and all set");

endmodule
`default_nettype wire
